>>> hw/rtl/pcc_pkg.sv
// Shared constants, payload structs, node-store entry and control types for the prefix code checker.
package pcc_pkg;

    localparam int MAX_NODES    = 256;
    localparam int MAX_CODE_LEN = 10;

    localparam int CODE_W  = 10;
    localparam int LEN_W   = 4;
    localparam int SET_W   = 16;
    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = NODE_W + 1;

    typedef struct packed {
        logic              mode;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } item_t;

    typedef struct packed {
        logic             decodable;
        logic [SET_W-1:0] set_index;
        logic             overflow;
    } result_t;

    // One trie node: a word-end mark and two child links, where zero means no child.
    typedef struct packed {
        logic                   mark;
        logic [1:0][NODE_W-1:0] child;
    } entry_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_STEP,
        ST_FINISH,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic report;
        logic clear_root;
    } cmd_t;

    typedef struct packed {
        logic item_empty;
        logic last;
        logic need_alloc;
        logic full;
    } status_t;

endpackage

>>> hw/rtl/pcc_ctrl.sv
// Controller state machine that sequences the trie walk of each transaction.
module pcc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             mode,
    input  pcc_pkg::status_t status,
    output pcc_pkg::cmd_t    cmd,
    output logic             busy
);

    pcc_pkg::state_t state_reg;
    pcc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcc_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            pcc_pkg::ST_INIT,
            pcc_pkg::ST_CLEAR:
            begin
                cmd.clear_root = 1'b1;
                state_next     = pcc_pkg::ST_IDLE;
            end
            pcc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (mode == pcc_pkg::MODE_REPORT)
                    begin
                        cmd.report = 1'b1;
                        state_next = pcc_pkg::ST_CLEAR;
                    end
                    else if (!status.item_empty)
                    begin
                        cmd.load   = 1'b1;
                        state_next = pcc_pkg::ST_STEP;
                    end
                end
            end
            pcc_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.need_alloc && status.full)
                begin
                    state_next = pcc_pkg::ST_IDLE;
                end
                else if (status.last)
                begin
                    state_next = pcc_pkg::ST_FINISH;
                end
            end
            pcc_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = pcc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/pcc_datapath.sv
// Datapath with the trie node store, walk registers, set flags and result register.
module pcc_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  pcc_pkg::item_t   item,
    input  pcc_pkg::cmd_t    cmd,
    output pcc_pkg::status_t status,
    output pcc_pkg::result_t result,
    output logic             result_valid
);

    pcc_pkg::entry_t mem [pcc_pkg::MAX_NODES];
    pcc_pkg::entry_t rd_data_reg;

    logic [pcc_pkg::CODE_W-1:0] bits_reg;
    logic [pcc_pkg::LEN_W-1:0]  pos_reg;
    logic [pcc_pkg::NODE_W-1:0] node_reg;
    logic                       fresh_reg;
    logic [pcc_pkg::CNT_W-1:0]  node_count_reg;
    logic                       conflict_reg;
    logic                       overflow_reg;
    logic [pcc_pkg::SET_W-1:0]  set_count_reg;
    pcc_pkg::result_t           result_reg;
    logic                       result_valid_reg;

    logic [pcc_pkg::LEN_W-1:0]  len_sat;
    pcc_pkg::entry_t            cur_entry;
    logic                       sym;
    logic [pcc_pkg::NODE_W-1:0] next_node;
    logic [pcc_pkg::NODE_W-1:0] new_node;
    logic                       need_alloc;
    logic                       full;
    logic                       alloc;
    logic                       wr_en;
    logic [pcc_pkg::NODE_W-1:0] wr_addr;
    pcc_pkg::entry_t            wr_data;
    logic [pcc_pkg::NODE_W-1:0] rd_addr;

    assign len_sat = (item.code_length > pcc_pkg::LEN_W'(pcc_pkg::MAX_CODE_LEN))
                   ? pcc_pkg::LEN_W'(pcc_pkg::MAX_CODE_LEN) : item.code_length;

    // A freshly allocated node has not been written yet and reads as empty.
    assign cur_entry  = fresh_reg ? '0 : rd_data_reg;
    assign sym        = bits_reg[pos_reg];
    assign next_node  = cur_entry.child[sym];
    assign need_alloc = (next_node == '0);
    assign full       = (node_count_reg >= pcc_pkg::CNT_W'(pcc_pkg::MAX_NODES - 1));
    assign new_node   = node_count_reg[pcc_pkg::NODE_W-1:0] + pcc_pkg::NODE_W'(1);
    assign alloc      = cmd.step && need_alloc && !full;

    assign status.item_empty = (item.code_length == '0);
    assign status.last       = (pos_reg == '0);
    assign status.need_alloc = need_alloc;
    assign status.full       = full;

    assign rd_addr = (cmd.step && !need_alloc) ? next_node : '0;

    always_comb
    begin
        wr_en   = cmd.clear_root || cmd.finish || (cmd.step && need_alloc);
        wr_addr = node_reg;
        wr_data = cur_entry;
        if (cmd.clear_root)
        begin
            wr_addr = '0;
            wr_data = '0;
        end
        else if (cmd.finish)
        begin
            wr_data.mark = 1'b1;
        end
        else if (alloc)
        begin
            wr_data.child[sym] = new_node;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg <= item.code_bits;
            pos_reg  <= len_sat - pcc_pkg::LEN_W'(1);
            node_reg <= '0;
        end
        else if (cmd.step)
        begin
            pos_reg  <= pos_reg - pcc_pkg::LEN_W'(1);
            node_reg <= need_alloc ? new_node : next_node;
        end
        if (cmd.report)
        begin
            result_reg.decodable <= !conflict_reg;
            result_reg.set_index <= set_count_reg;
            result_reg.overflow  <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg        <= 1'b0;
            node_count_reg   <= '0;
            conflict_reg     <= 1'b0;
            overflow_reg     <= 1'b0;
            set_count_reg    <= pcc_pkg::SET_W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.report;
            if (cmd.load)
            begin
                fresh_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                fresh_reg <= need_alloc;
            end
            if (cmd.report)
            begin
                node_count_reg <= '0;
                conflict_reg   <= 1'b0;
                overflow_reg   <= 1'b0;
                set_count_reg  <= (set_count_reg == '1) ? pcc_pkg::SET_W'(1)
                                : set_count_reg + pcc_pkg::SET_W'(1);
            end
            else
            begin
                if (alloc)
                begin
                    node_count_reg <= node_count_reg + pcc_pkg::CNT_W'(1);
                end
                if (cmd.step && need_alloc && full)
                begin
                    overflow_reg <= 1'b1;
                end
                if (cmd.step && cur_entry.mark)
                begin
                    conflict_reg <= 1'b1;
                end
                if (cmd.finish && (cur_entry.child != '0))
                begin
                    conflict_reg <= 1'b1;
                end
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> hw/rtl/prefix_code_checker_top.sv
// Top level of the prefix code checker: controller plus trie datapath.
// A codeword transaction keeps busy high after acceptance while it walks its code,
// whose length is saturated to 10: one trie level per cycle and then a final
// step that marks the word end; each level is one read of the node store port.
// An end-of-set result comes in the next cycle; busy stays up while the root clears.
// Reset clears all flags, sets the set number to one and then empties the root.
module prefix_code_checker_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pcc_pkg::item_t   item,
    output logic             busy,
    output pcc_pkg::result_t result,
    output logic             result_valid
);

    // Commands from the controller and status back from the datapath.
    pcc_pkg::cmd_t    cmd;
    pcc_pkg::status_t status;

    // The controller accepts a transaction only in its idle state and steps the walk
    // one symbol per cycle until the word ends or the node store runs out.
    pcc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds the node store; nodes are emptied as they are allocated, so
    // only the root needs clearing at the end of each set. The result is registered
    // and shown with its strobe for exactly one cycle.
    pcc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
